// ===== rtl/core/point_in_polygon_test_defines.svh =====
// Assertion macros shared by the point-in-polygon checker
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH
// implication checked on every clock, quiet during reset
`define PIP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PIP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/core/pip_pkg.sv =====
// Package: constants, types and orientation helper for the point-in-polygon test
package pip_pkg;
    localparam int MaxVerticesDefault = 64;
    localparam int CoordW = 32;
    localparam int DiffW = 34;
    localparam int ProdW = 68;
    localparam logic signed [CoordW-1:0] RayEndLng = 32'sd1518338048;
    localparam int MinPoly = 3;

    localparam logic [1:0] OR_COL = 2'd0;
    localparam logic [1:0] OR_POS = 2'd1;
    localparam logic [1:0] OR_NEG = 2'd2;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [DiffW-1:0] diff_t;
    typedef logic signed [ProdW-1:0] prod_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_point;   // capture test point, clear parity
        logic load_a;       // latch first vertex
        logic load_first;   // keep vertex 0 for the closing edge
        logic step;         // evaluate edge (a, b=read data)
        logic close;        // b is vertex 0
    } pip_cmd_t;

    typedef struct packed {
        logic hit;          // edge decision is final
        logic hit_val;
        logic parity;
    } pip_sts_t;

    function automatic logic [1:0] orient_code(input prod_t m1, input prod_t m2);
        logic [1:0] r;
        begin
            if (m1 == m2) r = OR_COL;
            else if (m1 > m2) r = OR_POS;
            else r = OR_NEG;
            return r;
        end
    endfunction
endpackage

// ===== rtl/core/pip_ram.sv =====
// Generic single-port write, registered-read RAM
module pip_ram #(
    parameter int Width = 64,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/pip_datapath.sv =====
// Datapath: edge-versus-ray orientation products, intersection and parity
module pip_datapath
    import pip_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pip_cmd_t cmd,
    input  coord_t   in_lat,
    input  coord_t   in_lng,
    input  logic [2*CoordW-1:0] rd_data,
    output pip_sts_t sts
);
    // stage 1: products; stage 2: decisions
    coord_t t_lat_reg, t_lng_reg, a_lat_reg, a_lng_reg, f_lat_reg, f_lng_reg;
    coord_t b_lat, b_lng;
    logic parity_reg, parity_next;
    logic hit_reg, hit_next, hitv_reg, hitv_next;

    prod_t p_reg [10];
    prod_t p_next [10];
    logic s1_vld_reg;
    logic [6:0] box_reg, box_next;

    assign b_lat = cmd.close ? f_lat_reg : coord_t'(rd_data[2*CoordW-1:CoordW]);
    assign b_lng = cmd.close ? f_lng_reg : coord_t'(rd_data[CoordW-1:0]);

    function automatic diff_t df(input coord_t x, input coord_t y);
        return diff_t'(x) - diff_t'(y);
    endfunction

    always_comb
    begin
        diff_t e_lng;
        e_lng = diff_t'(RayEndLng);
        // orient(p,q,r): (q.lat-p.lat)(r.lng-q.lng) vs (q.lng-p.lng)(r.lat-q.lat)
        p_next[0] = df(b_lat, a_lat_reg) * df(t_lng_reg, b_lng);          // o1 (a,b,t)
        p_next[1] = df(b_lng, a_lng_reg) * df(t_lat_reg, b_lat);
        p_next[2] = df(b_lat, a_lat_reg) * (e_lng - diff_t'(b_lng));      // o2 (a,b,e)
        p_next[3] = df(b_lng, a_lng_reg) * df(t_lat_reg, b_lat);
        p_next[4] = prod_t'(0);                                           // o3 (t,e,a): dlat=0
        p_next[5] = (e_lng - diff_t'(t_lng_reg)) * df(a_lat_reg, t_lat_reg);
        p_next[6] = prod_t'(0);                                           // o4 (t,e,b)
        p_next[7] = (e_lng - diff_t'(t_lng_reg)) * df(b_lat, t_lat_reg);
        p_next[8] = df(t_lat_reg, a_lat_reg) * df(b_lng, t_lng_reg);      // (a,t,b)
        p_next[9] = df(t_lng_reg, a_lng_reg) * df(b_lat, t_lat_reg);
        // in_box(a,t,b), in_box(a,e,b), in_box(t,a,e), in_box(t,b,e), lat parts shared
        box_next[0] = (t_lng_reg <= ((a_lng_reg > b_lng) ? a_lng_reg : b_lng)) &&
                      (t_lng_reg >= ((a_lng_reg < b_lng) ? a_lng_reg : b_lng));
        box_next[1] = (t_lat_reg <= ((a_lat_reg > b_lat) ? a_lat_reg : b_lat)) &&
                      (t_lat_reg >= ((a_lat_reg < b_lat) ? a_lat_reg : b_lat));
        box_next[2] = (RayEndLng <= ((a_lng_reg > b_lng) ? a_lng_reg : b_lng)) &&
                      (RayEndLng >= ((a_lng_reg < b_lng) ? a_lng_reg : b_lng));
        box_next[3] = (a_lng_reg <= ((t_lng_reg > RayEndLng) ? t_lng_reg : RayEndLng)) &&
                      (a_lng_reg >= ((t_lng_reg < RayEndLng) ? t_lng_reg : RayEndLng));
        box_next[4] = (a_lat_reg == t_lat_reg);
        box_next[5] = (b_lng <= ((t_lng_reg > RayEndLng) ? t_lng_reg : RayEndLng)) &&
                      (b_lng >= ((t_lng_reg < RayEndLng) ? t_lng_reg : RayEndLng));
        box_next[6] = (b_lat == t_lat_reg);
    end

    always_comb
    begin
        logic [1:0] o1, o2, o3, o4, o5;
        logic cr;
        o1 = orient_code(p_reg[0], p_reg[1]);
        o2 = orient_code(p_reg[2], p_reg[3]);
        o3 = orient_code(p_reg[4], p_reg[5]);
        o4 = orient_code(p_reg[6], p_reg[7]);
        o5 = orient_code(p_reg[8], p_reg[9]);
        cr = ((o1 != o2) && (o3 != o4)) ||
             ((o1 == OR_COL) && box_reg[0] && box_reg[1]) ||
             ((o2 == OR_COL) && box_reg[2] && box_reg[1]) ||
             ((o3 == OR_COL) && box_reg[3] && box_reg[4]) ||
             ((o4 == OR_COL) && box_reg[5] && box_reg[6]);
        parity_next = parity_reg;
        hit_next = hit_reg;
        hitv_next = hitv_reg;
        if (cmd.load_point)
        begin
            parity_next = 1'b0;
            hit_next = 1'b0;
            hitv_next = 1'b0;
        end
        else if (s1_vld_reg && cr && !hit_reg)
        begin
            if (o5 == OR_COL)
            begin
                hit_next = 1'b1;
                hitv_next = box_reg[0] && box_reg[1];
            end
            else
            begin
                parity_next = ~parity_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_point)
        begin
            t_lat_reg <= in_lat;
            t_lng_reg <= in_lng;
        end
        if (cmd.load_a)
        begin
            a_lat_reg <= coord_t'(rd_data[2*CoordW-1:CoordW]);
            a_lng_reg <= coord_t'(rd_data[CoordW-1:0]);
        end
        else if (cmd.step)
        begin
            a_lat_reg <= b_lat;
            a_lng_reg <= b_lng;
        end
        if (cmd.load_first)
        begin
            f_lat_reg <= coord_t'(rd_data[2*CoordW-1:CoordW]);
            f_lng_reg <= coord_t'(rd_data[CoordW-1:0]);
        end
        for (int k = 0; k < 10; k++)
        begin
            p_reg[k] <= p_next[k];
        end
        box_reg <= box_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            parity_reg <= 1'b0;
            hit_reg <= 1'b0;
            hitv_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.step;
            parity_reg <= parity_next;
            hit_reg <= hit_next;
            hitv_reg <= hitv_next;
        end
    end

    assign sts.hit = hit_reg;
    assign sts.hit_val = hitv_reg;
    assign sts.parity = parity_reg;
endmodule

// ===== rtl/core/pip_ctrl.sv =====
// Controller: vertex loads, edge walk sequencing and result register
module pip_ctrl
    import pip_pkg::*;
#(
    parameter int MaxVertices = MaxVerticesDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_acc,
    input  logic     mode,
    input  logic [6:0] count_cfg,
    input  pip_sts_t sts,
    input  logic     out_stall,
    output logic     in_stall,
    output logic     out_valid,
    output logic     inside_res,
    output pip_cmd_t cmd,
    output logic [$clog2(MaxVertices)-1:0] raddr
);
    localparam int AW = $clog2(MaxVertices);
    localparam int CW = $clog2(MaxVertices + 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIRST = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next, n_reg, n_next;
    logic [1:0] drain_reg, drain_next;
    logic ov_reg, ov_next, res_reg, res_next;
    logic [CW-1:0] n_eff;

    assign n_eff = (32'(count_cfg) > 32'(MaxVertices)) ? CW'(MaxVertices) : CW'(count_cfg);
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign out_valid = ov_reg;
    assign inside_res = res_reg;
    // address the next index so read data lines up with idx_reg
    assign raddr = idx_next[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        drain_next = drain_reg;
        ov_next = ov_reg && out_stall;
        res_next = res_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && mode)
                begin
                    if (n_eff < CW'(MinPoly))
                    begin
                        ov_next = 1'b1;
                        res_next = 1'b0;
                    end
                    else
                    begin
                        cmd.load_point = 1'b1;
                        n_next = n_eff;
                        idx_next = '0;
                        state_next = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                // read data is vertex 0
                cmd.load_a = 1'b1;
                cmd.load_first = 1'b1;
                idx_next = CW'(1);
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // memory reads idx+1 ahead; closing edge uses the kept vertex 0
                cmd.step = 1'b1;
                if (idx_reg == n_reg)
                begin
                    cmd.close = 1'b1;
                    drain_next = 2'd2;
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_DRAIN:
            begin
                drain_next = drain_reg - 2'd1;
                if (drain_reg == 2'd1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    res_next = sts.hit ? sts.hit_val : sts.parity;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            n_reg <= '0;
            drain_reg <= '0;
            ov_reg <= 1'b0;
            res_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
            drain_reg <= drain_next;
            ov_reg <= ov_next;
            res_reg <= res_next;
        end
    end
endmodule

// ===== rtl/core/point_in_polygon_test.sv =====
// Top level of the point-in-polygon ray casting test
// channel | direction | payload
// in      | input     | mode, vertex_index, coord_lat, coord_lng
// out     | output    | inside_res
// cfg     | input     | vertex_count (cfg_we, cfg_data)
// Vertex load: one RAM write per beat. Test: the walk evaluates one edge per cycle,
// set by the single vertex RAM read port; below three vertices the result is 0 without a walk.
// Reset clears the count and control; the vertex RAM is undefined until written.
// Input stalls while a test runs or while a result beat waits under stall.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MaxVertices = MaxVerticesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [5:0]  vertex_index,
    input  logic signed [31:0] coord_lat,
    input  logic signed [31:0] coord_lng,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        inside_res
);
    localparam int AW = $clog2(MaxVertices);
    logic [6:0] count_reg;
    logic in_acc, we;
    pip_cmd_t cmd;
    pip_sts_t sts;
    logic [AW-1:0] raddr;
    logic [2*CoordW-1:0] rd_data;

    assign in_acc = in_valid && !in_stall;
    assign we = in_acc && !mode && ({26'd0, vertex_index} < 32'(MaxVertices));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            count_reg <= cfg_data;
        end
    end

    pip_ram #(.Width(2*CoordW), .Depth(MaxVertices)) u_ram (
        .clk(clk), .we(we), .waddr(AW'(vertex_index)),
        .wdata({coord_lat, coord_lng}), .raddr(raddr), .rdata(rd_data)
    );

    pip_ctrl #(.MaxVertices(MaxVertices)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_acc(in_acc), .mode(mode),
        .count_cfg(count_reg), .sts(sts), .out_stall(out_stall),
        .in_stall(in_stall), .out_valid(out_valid), .inside_res(inside_res),
        .cmd(cmd), .raddr(raddr)
    );

    pip_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_lat(coord_lat),
        .in_lng(coord_lng), .rd_data(rd_data), .sts(sts)
    );
endmodule

// ===== rtl/core/pip_checker.sv =====
// Port-level checker for the point-in-polygon test, bound to the top level
`include "point_in_polygon_test_defines.svh"
module pip_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic mode,
    input logic out_valid,
    input logic out_stall,
    input logic inside_res
);
    `PIP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(inside_res), "stalled result beat changed")
    `PIP_ASSERT_NXT(a_test_busy, clk, rst_n, in_valid && !in_stall && mode, in_stall || out_valid, "test accepted without work or result")
    `PIP_ASSERT_NXT(a_load_silent, clk, rst_n, in_valid && !in_stall && !mode && !out_valid, !out_valid, "vertex load made a result")
endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .out_valid(out_valid), .out_stall(out_stall), .inside_res(inside_res)
);

// ===== tb/point_in_polygon_test_test.sv =====
// Testbench for the point-in-polygon block: directed and random vertex loads and tests
module point_in_polygon_test_test;
    import pip_pkg::*;

    localparam int NumVert = 64;
    localparam logic ModeLoad = 1'b0;
    localparam logic ModeTest = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [5:0]  idx;
        logic signed [31:0] lat;
        logic signed [31:0] lng;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [6:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic mode = 1'b0;
    logic [5:0] vertex_index = '0;
    logic signed [31:0] coord_lat = '0;
    logic signed [31:0] coord_lng = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic inside_res;

    point_in_polygon_test dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .vertex_index(vertex_index), .coord_lat(coord_lat), .coord_lng(coord_lng),
        .out_valid(out_valid), .out_stall(out_stall), .inside_res(inside_res)
    );

    beat_t pending_q[$];
    logic expected_inside_q[$];
    logic signed [63:0] poly_lat[NumVert];
    logic signed [63:0] poly_lng[NumVert];
    logic [6:0] poly_count = '0;
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_cycles = 0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // sign: 0 collinear, 1 positive, 2 negative
    function automatic int orient_sign(input logic signed [63:0] plat, plng, qlat, qlng,
                                       rlat, rlng);
        logic signed [127:0] m1;
        logic signed [127:0] m2;
        begin
            m1 = (128'(qlat) - plat) * (128'(rlng) - qlng);
            m2 = (128'(qlng) - plng) * (128'(rlat) - qlat);
            if (m1 == m2) return 0;
            return (m1 > m2) ? 1 : 2;
        end
    endfunction

    function automatic bit in_bbox(input logic signed [63:0] plat, plng, qlat, qlng,
                                   rlat, rlng);
        begin
            return ((qlng <= plng) || (qlng <= rlng)) && ((qlng >= plng) || (qlng >= rlng))
                && ((qlat <= plat) || (qlat <= rlat)) && ((qlat >= plat) || (qlat >= rlat));
        end
    endfunction

    function automatic logic point_inside(input logic signed [63:0] tlat, tlng);
        int n;
        int j;
        int o1, o2, o3, o4;
        bit hit;
        logic par;
        logic signed [63:0] alat, alng, blat, blng, elng;
        begin
            n = (poly_count > NumVert) ? NumVert : poly_count;
            par = 1'b0;
            elng = 64'(RayEndLng);
            if (n < MinPoly) return 1'b0;
            for (int i = 0; i < n; i++)
            begin
                j = (i + 1 == n) ? 0 : i + 1;
                alat = poly_lat[i]; alng = poly_lng[i];
                blat = poly_lat[j]; blng = poly_lng[j];
                o1 = orient_sign(alat, alng, blat, blng, tlat, tlng);
                o2 = orient_sign(alat, alng, blat, blng, tlat, elng);
                o3 = orient_sign(tlat, tlng, tlat, elng, alat, alng);
                o4 = orient_sign(tlat, tlng, tlat, elng, blat, blng);
                hit = (o1 != o2 && o3 != o4)
                    || (o1 == 0 && in_bbox(alat, alng, tlat, tlng, blat, blng))
                    || (o2 == 0 && in_bbox(alat, alng, tlat, elng, blat, blng))
                    || (o3 == 0 && in_bbox(tlat, tlng, alat, alng, tlat, elng))
                    || (o4 == 0 && in_bbox(tlat, tlng, blat, blng, tlat, elng));
                if (hit)
                begin
                    if (orient_sign(alat, alng, tlat, tlng, blat, blng) == 0)
                        return in_bbox(alat, alng, tlat, tlng, blat, blng);
                    par = ~par;
                end
            end
            return par;
        end
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!in_valid || !in_stall)
        begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                beat_t b;
                b = pending_q.pop_front();
                in_valid <= 1'b1;
                mode <= b.mode;
                vertex_index <= b.idx;
                coord_lat <= b.lat;
                coord_lng <= b.lng;
                if (b.mode == ModeLoad)
                begin
                    poly_lat[b.idx] = b.lat;
                    poly_lng[b.idx] = b.lng;
                end
                else
                    expected_inside_q.insert(expected_inside_q.size(),
                                             point_inside(b.lat, b.lng));
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall and monitor
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall);
        if (out_valid && !out_stall)
        begin
            if (expected_inside_q.size() == 0)
            begin
                $display("%0t: unexpected result inside_res=%0b", $time, inside_res);
                errors <= errors + 1;
            end
            else
            begin
                logic e;
                e = expected_inside_q.pop_front();
                if (e !== inside_res)
                begin
                    $display("%0t: inside_res expected %0b actual %0b", $time, e, inside_res);
                    errors <= errors + 1;
                end
            end
        end
    end

    task automatic drain();
        begin
            while (pending_q.size() > 0 || in_valid || expected_inside_q.size() > 0)
                @(posedge clk);
            repeat (80) @(posedge clk);
        end
    endtask

    task automatic set_count(input int n);
        begin
            cfg_we <= 1'b1;
            cfg_data <= 7'(n);
            poly_count = 7'(n);
            @(posedge clk);
            cfg_we <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_coord();
        int r;
        begin
            r = $urandom_range(9);
            if (r == 0) return 32'(1518338048);
            if (r == 1) return -32'sd1518338048;
            if (r == 2) return $urandom();
            if (r < 6) return 32'($urandom_range(200)) - 100;
            return 32'($urandom_range(2000000)) - 1000000;
        end
    endfunction

    task automatic queue_load(input int i, input logic signed [31:0] la, ln);
        beat_t b;
        begin
            b.mode = ModeLoad; b.idx = 6'(i); b.lat = la; b.lng = ln;
            pending_q.insert(pending_q.size(), b);
        end
    endtask

    task automatic queue_test(input logic signed [31:0] la, ln);
        beat_t b;
        begin
            b.mode = ModeTest; b.idx = 6'($urandom()); b.lat = la; b.lng = ln;
            pending_q.insert(pending_q.size(), b);
        end
    endtask

    // load a polygon of n vertices into slots 0 to n-1
    task automatic queue_polygon(input int n, input bit grid);
        begin
            for (int i = 0; i < n; i++)
                if (grid)
                    queue_load(i, 32'($urandom_range(8)) * 10 - 40,
                               32'($urandom_range(8)) * 10 - 40);
                else
                    queue_load(i, rand_coord(), rand_coord());
        end
    endtask

    task automatic queue_tests(input int k, input bit grid);
        begin
            for (int i = 0; i < k; i++)
                if (grid)
                    queue_test(32'($urandom_range(16)) * 5 - 40,
                               32'($urandom_range(16)) * 5 - 40);
                else
                    queue_test(rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        int phase;
        int n;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // fill every slot so no test reads an unwritten vertex
        queue_polygon(NumVert, 1'b0);
        // directed: square, points inside, on edges, vertex, outside
        queue_load(0, 0, 0); queue_load(1, 0, 100);
        queue_load(2, 100, 100); queue_load(3, 100, 0);
        drain();
        set_count(0);
        queue_test(50, 50);
        drain();
        set_count(2);
        queue_test(0, 50);
        drain();
        set_count(4);
        queue_test(50, 50); queue_test(0, 50); queue_test(0, 0);
        queue_test(100, 100); queue_test(50, 150); queue_test(50, -10);
        queue_test(100, 50); queue_test(-1, 50); queue_test(50, 0);
        queue_test(32'h7fffffff, 32'h80000000); queue_test(32'h80000000, 32'h7fffffff);
        queue_test(-32'sd1518338048, 32'sd1518338048);
        queue_load(63, 32'h7fffffff, 32'h80000000);
        drain();
        set_count(127);
        queue_test(50, 50); queue_test(32'h80000000, 32'h80000000);
        drain();
        for (phase = 0; phase < 24; phase++)
        begin
            case (phase % 4)
                0: begin send_idle = 0; recv_stall = 0; end
                1: begin send_idle = 85; recv_stall = 0; end
                2: begin send_idle = 0; recv_stall = 85; end
                default: begin send_idle = 24; recv_stall = 24; end
            endcase
            n = (phase == 5) ? 64 : (phase == 11) ? 127 : (phase == 17) ? 3
                : $urandom_range(3, 12);
            set_count(n);
            if (phase == 6)
                hold_cycles = 600;
            queue_polygon(n > NumVert ? NumVert : n, 1'(phase % 2));
            queue_tests((n > 20) ? 15 : 60, 1'(phase % 2));
            if (phase % 3 == 0)
            begin
                queue_load($urandom_range(63), rand_coord(), rand_coord());
                queue_tests(5, 1'b0);
            end
            drain();
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pip_pkg.sv
rtl/core/pip_ram.sv
rtl/core/pip_datapath.sv
rtl/core/pip_ctrl.sv
rtl/core/point_in_polygon_test.sv
rtl/core/pip_checker.sv
tb/point_in_polygon_test_test.sv
